### rtl/skf_pkg.sv
package skf_pkg;

    localparam int STEP_W = 4;

    // configuration register indexes
    localparam logic [1:0] REG_PROCESS_NOISE      = 2'd0;
    localparam logic [1:0] REG_MEASUREMENT_NOISE  = 2'd1;
    localparam logic [1:0] REG_INITIAL_ESTIMATE   = 2'd2;
    localparam logic [1:0] REG_INITIAL_COVARIANCE = 2'd3;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_WAIT_IN,
        OP_PRED,
        OP_PREP,
        OP_DIV,
        OP_MUL_HI,
        OP_MUL_LO,
        OP_EST,
        OP_COV,
        OP_OUT
    } t_op;

    typedef enum logic {
        SEL_INNOV,
        SEL_COV
    } t_sel;

    typedef enum logic [1:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_DEN_ZERO,
        COND_DIV_MORE
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_sel              sel;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        t_sel sel;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic den_zero;
        logic div_last;
    } t_flags;

    localparam logic [STEP_W-1:0] STEP_WAIT   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DIV    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_MUL_IN = 4'd4;

    // control store: one word per step
    function automatic t_uword skf_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            4'd0:    w = '{OP_WAIT_IN, SEL_INNOV, COND_NEVER,    STEP_WAIT};
            4'd1:    w = '{OP_PRED,    SEL_INNOV, COND_NEVER,    STEP_WAIT};
            4'd2:    w = '{OP_PREP,    SEL_INNOV, COND_DEN_ZERO, STEP_MUL_IN};
            4'd3:    w = '{OP_DIV,     SEL_INNOV, COND_DIV_MORE, STEP_DIV};
            4'd4:    w = '{OP_MUL_HI,  SEL_INNOV, COND_NEVER,    STEP_WAIT};
            4'd5:    w = '{OP_MUL_LO,  SEL_INNOV, COND_NEVER,    STEP_WAIT};
            4'd6:    w = '{OP_EST,     SEL_INNOV, COND_NEVER,    STEP_WAIT};
            4'd7:    w = '{OP_MUL_HI,  SEL_COV,   COND_NEVER,    STEP_WAIT};
            4'd8:    w = '{OP_MUL_LO,  SEL_COV,   COND_NEVER,    STEP_WAIT};
            4'd9:    w = '{OP_COV,     SEL_COV,   COND_NEVER,    STEP_WAIT};
            4'd10:   w = '{OP_OUT,     SEL_COV,   COND_ALWAYS,   STEP_WAIT};
            default: w = '{OP_NOP,     SEL_INNOV, COND_ALWAYS,   STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

### rtl/scalar_kalman_filter_unit.sv
// scalar kalman filter, one result per sample, microcoded over a shared datapath
// steps in order: take sample, predict, prepare, gain divide (one quotient bit per cycle),
// estimate multiply and update, covariance multiply and update, then output the result
// a zero gain denominator skips the divide; a sample is taken only in the wait step
// the next sample is taken while a result still waits on the output register
// reset (synchronous, active low) loads the register defaults and the initial state
module scalar_kalman_filter_unit
    import skf_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [DATA_WIDTH-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // sample_value
    input  logic [((DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // filtered_value, error_covariance, gain_used
    output logic [((2*DATA_WIDTH+FRAC_BITS+1+7)/8)*8-1:0] m_axis_tdata
);

    localparam int W     = DATA_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int OUT_W = ((2*W+F+1+7)/8)*8;
    localparam int HI_W  = W + 1 - F;
    localparam int MA_W  = (HI_W > F) ? HI_W : F;
    localparam int PR_W  = MA_W + F + 1;
    localparam int CNT_W = $clog2(F + 1);

    localparam logic [W-1:0] Q_RESET = W'((64'd655 << F) >> 16);
    localparam logic [W-1:0] R_RESET = W'(64'd1 << (F - 2));
    localparam logic [W-1:0] P_RESET = W'(64'd1 << F);

    t_ctrl  ctrl;
    t_flags flags;

    // configuration and filter state
    logic [W-1:0] r_q;
    logic [W-1:0] r_r;
    logic [W-1:0] r_est;
    logic [W-1:0] r_cov;

    // working registers
    logic [W-1:0]     r_meas;
    logic [W-1:0]     r_phat;
    logic [W:0]       r_den;
    logic [W:0]       r_rem;
    logic [F:0]       r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [W:0]       r_mag;
    logic             r_neg;
    logic [W:0]       r_acc;

    logic         r_out_valid;
    logic [W-1:0] r_out_est;
    logic [W-1:0] r_out_cov;
    logic [F:0]   r_out_gain;

    logic [W:0]      phat_sum;
    logic [W-1:0]    phat_sat;
    logic [W:0]      den_c;
    logic [W:0]      diff;
    logic [W:0]      mag_c;
    logic [W+1:0]    div_t;
    logic [W+1:0]    div_sub;
    logic            div_ge;
    logic [MA_W-1:0] mul_a;
    logic [F:0]      mul_g;
    logic [PR_W-1:0] prod;
    logic [W+1:0]    est_x;
    logic [W+1:0]    dlt_x;
    logic [W+1:0]    est_sum;
    logic [W-1:0]    est_sat;
    logic            out_free;

    skf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctrl  (ctrl)
    );

    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        phat_sum = {1'b0, r_cov} + {1'b0, r_q};
        phat_sat = phat_sum[W] ? {W{1'b1}} : phat_sum[W-1:0];
        den_c    = {1'b0, r_phat} + {1'b0, r_r};
        diff     = {r_meas[W-1], r_meas} - {r_est[W-1], r_est};
        mag_c    = diff[W] ? (~diff + 1'b1) : diff;

        // restoring divide, first step compares without a shift
        div_t   = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
        div_ge  = (div_t >= {1'b0, r_den});
        div_sub = div_t - {1'b0, r_den};

        if (ctrl.sel == SEL_INNOV) begin
            mul_g = r_quo;
            if (ctrl.op == OP_MUL_HI) begin
                mul_a = MA_W'(r_mag[W:F]);
            end else begin
                mul_a = MA_W'(r_mag[F-1:0]);
            end
        end else begin
            mul_g = {1'b1, {F{1'b0}}} - r_quo;
            if (ctrl.op == OP_MUL_HI) begin
                mul_a = MA_W'(r_phat[W-1:F]);
            end else begin
                mul_a = MA_W'(r_phat[F-1:0]);
            end
        end
        prod = PR_W'(mul_a) * PR_W'(mul_g);

        est_x   = {{2{r_est[W-1]}}, r_est};
        dlt_x   = {1'b0, r_acc};
        est_sum = r_neg ? (est_x - dlt_x) : (est_x + dlt_x);
        if ((est_sum[W+1:W-1] == 3'b000) || (est_sum[W+1:W-1] == 3'b111)) begin
            est_sat = est_sum[W-1:0];
        end else if (est_sum[W+1]) begin
            est_sat = {1'b1, {(W-1){1'b0}}};
        end else begin
            est_sat = {1'b0, {(W-1){1'b1}}};
        end

        flags.in_valid = s_axis_tvalid;
        flags.out_free = out_free;
        flags.den_zero = (den_c == '0);
        flags.div_last = (r_cnt == CNT_W'(F));
    end

    // registers and state, written by the config port or by the program
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q   <= Q_RESET;
            r_r   <= R_RESET;
            r_est <= '0;
            r_cov <= P_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PROCESS_NOISE:      r_q   <= i_cfg_data;
                REG_MEASUREMENT_NOISE:  r_r   <= i_cfg_data;
                REG_INITIAL_ESTIMATE:   r_est <= i_cfg_data;
                REG_INITIAL_COVARIANCE: r_cov <= i_cfg_data;
                default: begin
                end
            endcase
        end else begin
            case (ctrl.op)
                OP_EST:  r_est <= est_sat;
                OP_COV:  r_cov <= r_acc[W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (ctrl.op)
            OP_WAIT_IN: begin
                r_meas <= s_axis_tdata[W-1:0];
            end
            OP_PRED: begin
                r_phat <= phat_sat;
            end
            OP_PREP: begin
                r_den <= den_c;
                r_rem <= {1'b0, r_phat};
                r_quo <= '0;
                r_cnt <= '0;
                r_mag <= mag_c;
                r_neg <= diff[W];
            end
            OP_DIV: begin
                r_rem <= div_ge ? div_sub[W:0] : div_t[W:0];
                r_quo <= {r_quo[F-1:0], div_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            OP_MUL_HI: begin
                r_acc <= prod[W:0];
            end
            OP_MUL_LO: begin
                r_acc <= r_acc + (W+1)'(prod[F +: F+1]);
            end
            OP_OUT: begin
                if (out_free) begin
                    r_out_est  <= r_est;
                    r_out_cov  <= r_cov;
                    r_out_gain <= r_quo;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((ctrl.op == OP_OUT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign s_axis_tready = (ctrl.op == OP_WAIT_IN);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_gain, r_out_cov, r_out_est});

endmodule

### rtl/skf_seq.sv
module skf_seq
    import skf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            uw;
    logic              stall;
    logic              take;

    always_comb begin
        uw = skf_rom(r_step);
        // waiting steps hold until their channel is ready
        stall = ((uw.op == OP_WAIT_IN) && !i_flags.in_valid) ||
                ((uw.op == OP_OUT) && !i_flags.out_free);
        case (uw.cond)
            COND_NEVER:    take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_DEN_ZERO: take = i_flags.den_zero;
            COND_DIV_MORE: take = !i_flags.div_last;
            default:       take = 1'b0;
        endcase
        if (stall) begin
            n_step = r_step;
        end else if (take) begin
            n_step = uw.target;
        end else begin
            n_step = r_step + 1'b1;
        end
        o_ctrl.op  = uw.op;
        o_ctrl.sel = uw.sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule
